// ----- design/rsst_pkg.sv -----
package rsst_pkg;

  localparam int DATA_W           = 32;
  localparam int IDX_W            = 10;
  localparam int CFG_W            = 11;
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int CMD_DEPTH        = 2;

  // Input tdata layout, lowest bit first.
  localparam int IN_TDATA_W = 64;
  localparam int ELEM_LSB   = 0;
  localparam int VALUE_LSB  = ELEM_LSB + IDX_W;
  localparam int LEFT_LSB   = VALUE_LSB + DATA_W;
  localparam int RIGHT_LSB  = LEFT_LSB + IDX_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_EMPTY
  } cmd_kind_t;

  // One classified command. For a write, a_idx is the element and value the data.
  // For a query, a_idx and b_idx are the inclusive bounds, with b_idx clipped to the count.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   a_idx;
    logic [IDX_W-1:0]   b_idx;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } fifo_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } fifo_rd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_W_LEAF,
    B_W_WALK,
    B_Q_WALK,
    B_Q_DRAIN,
    B_DONE
  } back_state_t;

endpackage

// ----- design/rsst_ram.sv -----
module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- design/rsst_fifo.sv -----
module rsst_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rsst_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output rsst_pkg::cmd_t    pop_cmd,
  output logic              empty
);
  import rsst_pkg::*;

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          slot_r [CMD_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign full     = (fill_r == CW'(CMD_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/rsst_front.sv -----
module rsst_front #(
  parameter int MAX_ELEMENTS = rsst_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rsst_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rsst_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              back_ready,
  output rsst_pkg::fifo_wr_t                fifo_wr,
  input  logic                              fifo_full,
  output rsst_pkg::cmd_t                    cmd
);
  import rsst_pkg::*;

  logic [CFG_W-1:0]  count_r, count_nxt;
  logic [CFG_W-1:0]  last_idx;
  logic [CFG_W-1:0]  hi_clip;
  logic [IDX_W-1:0]  elem_idx, left_idx, right_idx;
  logic [DATA_W-1:0] value;
  logic              accept;
  logic              write_ok;
  op_t               op;

  // Saturate a written count into 1..MAX_ELEMENTS.
  always_comb begin
    count_nxt = count_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        count_nxt = CFG_W'(1);
      end else if (32'(cfg_wdata) > 32'(MAX_ELEMENTS)) begin
        count_nxt = CFG_W'(MAX_ELEMENTS);
      end else begin
        count_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= (MAX_ELEMENTS < 1024) ? CFG_W'(MAX_ELEMENTS) : CFG_W'(1024);
    end else begin
      count_r <= count_nxt;
    end
  end

  assign op        = op_t'(in_tuser);
  assign elem_idx  = in_tdata[ELEM_LSB +: IDX_W];
  assign value     = in_tdata[VALUE_LSB +: DATA_W];
  assign left_idx  = in_tdata[LEFT_LSB +: IDX_W];
  assign right_idx = in_tdata[RIGHT_LSB +: IDX_W];

  assign last_idx  = count_r - CFG_W'(1);
  assign hi_clip   = ({1'b0, right_idx} > last_idx) ? last_idx : {1'b0, right_idx};
  assign write_ok  = ({1'b0, elem_idx} < count_r);

  assign in_tready = back_ready && !fifo_full;
  assign accept    = in_tvalid && in_tready;

  // Out-of-range writes are accepted and dropped here; they never reach the queue.
  always_comb begin
    cmd.value = value;
    unique case (op)
      OP_WRITE: begin
        cmd.kind  = CMD_WRITE;
        cmd.a_idx = elem_idx;
        cmd.b_idx = elem_idx;
        fifo_wr.push = accept && write_ok;
      end
      OP_QUERY: begin
        cmd.kind  = ({1'b0, left_idx} > hi_clip) ? CMD_EMPTY : CMD_QUERY;
        cmd.a_idx = left_idx;
        cmd.b_idx = hi_clip[IDX_W-1:0];
        fifo_wr.push = accept;
      end
      default: begin
        cmd.kind  = CMD_EMPTY;
        cmd.a_idx = left_idx;
        cmd.b_idx = right_idx;
        fifo_wr.push = 1'b0;
      end
    endcase
    fifo_wr.full = fifo_full;
  end

endmodule

// ----- design/rsst_back.sv -----
module rsst_back #(
  parameter int MAX_ELEMENTS = rsst_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsst_pkg::fifo_rd_t            fifo_rd_in,
  input  rsst_pkg::cmd_t                cmd,
  output logic                          fifo_pop,
  output logic                          ready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rsst_pkg::DATA_W-1:0]   out_tdata
);
  import rsst_pkg::*;

  localparam int LEAF_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 0;
  localparam int LEAVES = 1 << LEAF_W;
  localparam int DEPTH  = 2 * LEAVES;
  localparam int AW     = LEAF_W + 1;
  localparam int NW     = LEAF_W + 2;

  back_state_t       state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  logic              first_r, first_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] diff_r, diff_nxt;
  logic [NW-1:0]     l_r, l_nxt;
  logic [NW-1:0]     r_r, r_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              fa_r, fa_nxt;
  logic              fb_r, fb_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re_a, re_b;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  logic              out_free;

  rsst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign out_free   = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign ready      = (state_r != B_CLEAR);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    node_nxt   = node_r;
    first_nxt  = first_r;
    val_nxt    = val_r;
    diff_nxt   = diff_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    fa_nxt     = 1'b0;
    fb_nxt     = 1'b0;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    fifo_pop   = 1'b0;
    we         = 1'b0;
    waddr      = node_r;
    wdata      = '0;
    re_a       = 1'b0;
    re_b       = 1'b0;
    raddr_a    = node_r;
    raddr_b    = node_r;
    // Registered read data lands together with the registered flags fa_r and fb_r that asked for it.
    acc_nxt    = acc_r + (fa_r ? rdata_a : '0) + (fb_r ? rdata_b : '0);

    unique case (state_r)
      B_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        acc_nxt = '0;
        if (!fifo_rd_in.empty) begin
          fifo_pop = 1'b1;
          val_nxt  = cmd.value;
          node_nxt = AW'(LEAVES) + AW'(cmd.a_idx);
          l_nxt    = NW'(LEAVES) + NW'(cmd.a_idx);
          r_nxt    = NW'(LEAVES) + NW'(cmd.b_idx) + NW'(1);
          unique case (cmd.kind)
            CMD_WRITE: state_nxt = B_W_LEAF;
            CMD_QUERY: state_nxt = B_Q_WALK;
            default:   state_nxt = B_DONE;
          endcase
        end
      end
      B_W_LEAF: begin
        re_a      = 1'b1;
        raddr_a   = node_r;
        first_nxt = 1'b1;
        state_nxt = B_W_WALK;
      end
      B_W_WALK: begin
        // Write the node whose old sum just arrived and, below the root, fetch its parent.
        we    = 1'b1;
        waddr = node_r;
        if (first_r) begin
          wdata    = val_r;
          diff_nxt = val_r - rdata_a;
        end else begin
          wdata = rdata_a + diff_r;
        end
        first_nxt = 1'b0;
        if (node_r == AW'(1)) begin
          state_nxt = B_IDLE;
        end else begin
          re_a     = 1'b1;
          raddr_a  = node_r >> 1;
          node_nxt = node_r >> 1;
        end
      end
      B_Q_WALK: begin
        if (l_r < r_r) begin
          fa_nxt  = l_r[0];
          fb_nxt  = r_r[0];
          re_a    = l_r[0];
          raddr_a = AW'(l_r);
          re_b    = r_r[0];
          raddr_b = AW'(r_r - NW'(1));
          l_nxt   = (l_r + NW'(l_r[0])) >> 1;
          r_nxt   = r_r >> 1;
        end else begin
          state_nxt = B_Q_DRAIN;
        end
      end
      B_Q_DRAIN: begin
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = acc_r;
          state_nxt  = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      fa_r     <= 1'b0;
      fb_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      fa_r     <= fa_nxt;
      fb_r     <= fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    first_r <= first_nxt;
    val_r   <= val_nxt;
    diff_r  <= diff_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    acc_r   <= acc_nxt;
    odata_r <= odata_nxt;
  end

endmodule

// ----- design/range_sum_segment_tree.sv -----
// Point-update, range-sum segment tree over up to MAX_ELEMENTS signed 32-bit
// elements, with the leaf count rounded up to a power of two (L leaves). An op of
// write (tuser 0) stores a value and gives no output transfer; a query (tuser 1)
// gives one transfer with the wrapped sum over the inclusive range, zero when the
// clipped range is empty. Writes at or above element_count are dropped. A front
// stage classifies and clips each item into a two-entry queue, and a back stage
// walks the node-sum memory one tree level per cycle. In the back stage a write
// reads its leaf, then does one read-modify-write per level; a query reads both
// range edges per level through the two memory read ports, then takes an exit
// check, a drain and the output; an empty query goes straight to the output.
// After reset the node memory is cleared, during which in_tready stays low.
module range_sum_segment_tree #(
  parameter int MAX_ELEMENTS = rsst_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rsst_pkg::CFG_W-1:0]        cfg_wdata,   // element_count
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // elem_index[9:0], new_value[41:10], range_left[51:42], range_right[61:52], zero pad
  input  logic [rsst_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,    // op
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rsst_pkg::DATA_W-1:0]       out_tdata    // range_sum
);
  import rsst_pkg::*;

  fifo_wr_t fifo_wr;
  fifo_rd_t fifo_rd;
  cmd_t     push_cmd;
  cmd_t     pop_cmd;
  logic     fifo_full;
  logic     fifo_empty;
  logic     fifo_pop;
  logic     back_ready;

  rsst_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .back_ready (back_ready),
    .fifo_wr    (fifo_wr),
    .fifo_full  (fifo_full),
    .cmd        (push_cmd)
  );

  rsst_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_wr.push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  assign fifo_rd.pop   = fifo_pop;
  assign fifo_rd.empty = fifo_empty;

  rsst_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_rd_in (fifo_rd),
    .cmd        (pop_cmd),
    .fifo_pop   (fifo_pop),
    .ready      (back_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- dv/rsst_tb_pkg.sv -----
`timescale 1ns / 100ps

package rsst_tb_pkg;

  import rsst_pkg::*;

  // Tracks the element array as the block should see it and queues the
  // range sums that the block owes.
  class sum_scoreboard;
    logic [DATA_W-1:0] elems [MAX_ELEMENTS_DEF];
    int unsigned       elem_count;
    logic [DATA_W-1:0] sums_due [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      foreach (elems[i]) elems[i] = '0;
      elem_count = MAX_ELEMENTS_DEF;
      errors     = 0;
      checked    = 0;
    endfunction

    // The register keeps 11 bits and the count saturates into 1..MAX_ELEMENTS.
    function void set_count(int unsigned raw);
      int unsigned c;
      c = raw & ((1 << CFG_W) - 1);
      if (c < 1) c = 1;
      if (c > MAX_ELEMENTS_DEF) c = MAX_ELEMENTS_DEF;
      elem_count = c;
    endfunction

    function void note_input(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                             logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
      int unsigned       right;
      logic [DATA_W-1:0] acc;
      if (op == OP_WRITE) begin
        if (idx < elem_count) elems[idx] = val;
      end else begin
        right = hi;
        if (right > elem_count - 1) right = elem_count - 1;
        acc = '0;
        // Elements above the count keep their values, but clipping hides them.
        for (int i = lo; i <= int'(right); i++) acc += elems[i];
        sums_due.push_back(acc);
      end
    endfunction

    function void check_sum(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      checked++;
      if (sums_due.size() == 0) begin
        $error("range_sum: transfer with nothing expected, actual %0d", $signed(got));
        errors++;
      end else begin
        want = sums_due.pop_front();
        if (got !== want) begin
          $error("range_sum: expected %0d, actual %0d", $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_range_sum_segment_tree.sv -----
`timescale 1ns / 100ps

module tb_range_sum_segment_tree;

  import rsst_pkg::*;
  import rsst_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          SETTLE      = 64;
  localparam int          PHASE_ITEMS = 172;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;

  sum_scoreboard sb;
  logic          calm;
  int unsigned   cycles;
  int unsigned   n_writes;
  int unsigned   n_queries;
  int unsigned   n_settings;

  range_sum_segment_tree i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sum(out_tdata);
  end

  // Entered and left at a falling edge; in_tvalid is assigned once per edge.
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                           logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
    logic [IN_TDATA_W-1:0] word;
    while (!calm && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    word = '0;
    word[ELEM_LSB  +: IDX_W]  = idx;
    word[VALUE_LSB +: DATA_W] = val;
    word[LEFT_LSB  +: IDX_W]  = lo;
    word[RIGHT_LSB +: IDX_W]  = hi;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, idx, val, lo, hi);
    if (op == OP_WRITE) n_writes++;
    else n_queries++;
    @(negedge clk);
  endtask

  task automatic hold_until_empty();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Writes without a result may still be in the back stage, so wait them out.
  task automatic write_count(int unsigned value);
    hold_until_empty();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_count(value);
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int unsigned limit);
    if ($urandom_range(99) < 85) return IDX_W'($urandom_range(limit - 1));
    return IDX_W'($urandom_range(MAX_ELEMENTS_DEF - 1));
  endfunction

  task automatic random_phase(int n, bit pause_midway);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] tmp;
    for (int k = 0; k < n; k++) begin
      if (pause_midway && k == n / 2) hold_until_empty();
      lo = pick_index(sb.elem_count);
      hi = pick_index(sb.elem_count);
      // Mostly ordered bounds, with some reversed ones for empty ranges.
      if (lo > hi && $urandom_range(99) < 80) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      if ($urandom_range(99) < 55)
        send_item(OP_WRITE, pick_index(sb.elem_count), pick_value(),
                  IDX_W'($urandom), IDX_W'($urandom));
      else
        send_item(OP_QUERY, IDX_W'($urandom), $urandom, lo, hi);
    end
  endtask

  initial begin
    int unsigned counts [8];
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_WRITE;
    out_tready = 1'b0;
    calm       = 1'b0;
    cycles     = 0;
    n_writes   = 0;
    n_queries  = 0;
    n_settings = 1;
    sb         = new();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    // The node memory is cleared after reset; in_tready rises when done.
    do @(posedge clk); while (!in_tready);
    @(negedge clk);

    send_item(OP_QUERY, 0, 0, 0, 1023);
    send_item(OP_WRITE, 0, 32'h7FFF_FFFF, 0, 0);
    send_item(OP_WRITE, 1023, 32'h8000_0000, 0, 0);
    send_item(OP_WRITE, 5, 32'hFFFF_FFFF, 0, 0);
    send_item(OP_WRITE, 5, 32'h0000_0003, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 1023);
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 1023, 1023);
    send_item(OP_QUERY, 0, 0, 6, 4);
    send_item(OP_QUERY, 0, 0, 1023, 0);
    send_item(OP_WRITE, 1, 32'h7FFF_FFFF, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 1);

    // A count of zero saturates to one element.
    write_count(0);
    send_item(OP_WRITE, 1, 32'd5, 0, 0);
    send_item(OP_WRITE, 1023, 32'd9, 0, 0);
    send_item(OP_WRITE, 0, 32'hFFFF_FFFE, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 1023);
    send_item(OP_QUERY, 0, 0, 1, 1);

    // All ones saturates to the full size; hidden values come back into view.
    write_count(2047);
    send_item(OP_QUERY, 0, 0, 0, 1023);
    send_item(OP_QUERY, 0, 0, 2, 1022);

    write_count(513);
    send_item(OP_WRITE, 512, 32'd10, 0, 0);
    send_item(OP_WRITE, 513, 32'd11, 0, 0);
    send_item(OP_QUERY, 0, 0, 500, 1023);
    send_item(OP_QUERY, 0, 0, 513, 513);

    counts = '{1024, 16, 2047, 1, 700, 0, 1 + $urandom_range(1023), 1024};
    foreach (counts[p]) begin
      write_count(counts[p]);
      calm = (p == 4);
      random_phase(PHASE_ITEMS, p == 2);
    end
    calm = 1'b0;

    hold_until_empty();
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d writes and %0d queries across %0d element-count settings.",
             n_writes, n_queries, n_settings);
    $display("Checked %0d range sums, %0d still outstanding.", sb.checked, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rsst_pkg.sv
design/rsst_ram.sv
design/rsst_fifo.sv
design/rsst_front.sv
design/rsst_back.sv
design/range_sum_segment_tree.sv
dv/rsst_tb_pkg.sv
dv/tb_range_sum_segment_tree.sv
